FILE: hw/rtl/hrspc_pkg.sv
// Shared constants for the HDR RGB scale pixel codec.
`default_nettype none
package hrspc_pkg;
   localparam int unsigned CodeMax = 255;
   localparam int unsigned CodeSq  = 65025;
   localparam int unsigned QuotW   = 17;
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_OBRITE = 2'd1;
   localparam logic       MODE_ENC   = 1'b0;
   localparam logic       MODE_DEC   = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/hrspc_div.sv
// Pipelined restoring divider: 32-bit dividend by 32-bit divisor, 17-bit quotient, one bit a stage.
`default_nettype none
module hrspc_div (
   input  wire logic        clock,
   input  wire logic [31:0] num,
   input  wire logic [31:0] den,
   output logic [16:0]      quot
);
   import hrspc_pkg::*;
   logic [31:0] rem_ff [QuotW];
   logic [31:0] den_ff [QuotW];
   logic [16:0] q_ff   [QuotW+1];
   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
   end
   for (genvar k = 0; k < QuotW; k++) begin : g_st
      localparam int Sh = QuotW - 1 - k;
      logic [48:0] dsh;
      logic        ge;
      assign dsh = {17'd0, den_ff[k]} << Sh;
      assign ge  = {17'd0, rem_ff[k]} >= dsh;
      always_ff @(posedge clock) begin
         q_ff[k+1] <= {q_ff[k][15:0], ge};
      end
      if (k < QuotW - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - dsh[31:0] : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
         end
      end
   end
   assign quot = q_ff[QuotW];
endmodule
`default_nettype wire

FILE: hw/rtl/hdr_rgb_scale_pixel_codec.sv
// Top level of the HDR RGB scale pixel codec.
// channel | ports                                  | handshake
// req     | red/green/blue_in, scale_in            | start & !busy
// rsp     | red/green/blue_out, scale_out          | strobe, one cycle
// csr     | csr_we, csr_index, csr_wdata           | write at edge with csr_we
// One item per cycle, through two chained 17-stage bitwise dividers.
// busy is always low. Reset clears valid bits, sets mode to encode and obrite to 4096; no stall from the receiver.
`default_nettype none
module hdr_rgb_scale_pixel_codec (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_red_in,
   input  wire logic [15:0] req_green_in,
   input  wire logic [15:0] req_blue_in,
   input  wire logic [7:0]  req_scale_in,
   output logic             strobe,
   output logic [15:0]      rsp_red_out,
   output logic [15:0]      rsp_green_out,
   output logic [15:0]      rsp_blue_out,
   output logic [7:0]       rsp_scale_out,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import hrspc_pkg::*;
   localparam int Lat = QuotW + 2;
   localparam int Tot = 2 * Lat + 1;
   logic        mode_ff;
   logic [15:0] ob_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENC;
         ob_ff   <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff <= csr_wdata[0];
            CSR_OBRITE: ob_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end
   assign busy = 1'b0;

   // stage 0: clamp, max, decode code saturation
   logic [15:0] c_in [3];
   logic [15:0] raw [3];
   logic [15:0] m_in;
   assign raw[0] = req_red_in;
   assign raw[1] = req_green_in;
   assign raw[2] = req_blue_in;
   always_comb begin
      m_in = '0;
      for (int i = 0; i < 3; i++) begin
         c_in[i] = (raw[i] < ob_ff) ? raw[i] : ob_ff;
         if (c_in[i] > m_in) m_in = c_in[i];
      end
   end
   logic        v_ff [Tot+1];
   logic        md_ff [Tot+1];
   logic [7:0]  sc_ff [Tot+1];
   logic        blk_ff [Tot+1];
   logic [15:0] c_ff [3][Lat+1];
   logic [15:0] o_ff;
   logic [15:0] m_ff;
   logic [7:0]  cd_ff [3];
   logic [15:0] ob1_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= start;
      md_ff[0]  <= mode_ff;
      sc_ff[0]  <= req_scale_in;
      blk_ff[0] <= (m_in == 16'd0);
      m_ff      <= m_in;
      o_ff      <= ob_ff;
      ob1_ff    <= ob_ff;
      for (int i = 0; i < 3; i++) begin
         cd_ff[i]   <= (raw[i] > 16'd255) ? 8'd255 : raw[i][7:0];
      end
   end
   for (genvar k = 0; k < Tot; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else       v_ff[k+1] <= v_ff[k];
         md_ff[k+1]  <= md_ff[k];
         blk_ff[k+1] <= blk_ff[k];
         sc_ff[k+1]  <= sc_ff[k];
      end
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c_ff[i][0] <= c_in[i];
         for (int k = 0; k < Lat; k++) c_ff[i][k+1] <= c_ff[i][k];
      end
   end

   // stage 1: scale numerator; decode product scale*code
   logic [31:0] sn_ff, sd_ff;
   logic [15:0] sx_ff [3];
   always_ff @(posedge clock) begin
      sn_ff <= {8'd0, m_ff, 8'd0} - {16'd0, m_ff} + {16'd0, o_ff} - 32'd1;
      sd_ff <= (o_ff == 16'd0) ? 32'd1 : {16'd0, o_ff};
      for (int i = 0; i < 3; i++) sx_ff[i] <= {8'd0, sc_ff[0]} * {8'd0, cd_ff[i]};
   end
   logic [16:0] sq;
   hrspc_div u_sdiv (.clock(clock), .num(sn_ff), .den(sd_ff), .quot(sq));
   // sq valid at index Lat
   logic [15:0] ob_d_ff [Lat];
   always_ff @(posedge clock) begin
      ob_d_ff[0] <= ob1_ff;
      for (int k = 0; k < Lat - 1; k++) ob_d_ff[k+1] <= ob_d_ff[k];
   end
   logic [7:0] scl;
   assign scl = (sq > 17'd255) ? 8'd255 : sq[7:0];

   // encode den = scale*O ; decode num = sx*O
   logic [31:0] en_num [3];
   logic [31:0] den_ff, dn_ff [3];
   logic [7:0]  scl_ff;
   logic [31:0] num_ff [3];
   always_ff @(posedge clock) begin
      scl_ff <= scl;
      den_ff <= {8'd0, scl, 16'd0} == 32'd0 ? 32'd1 : {16'd0, 8'd0, scl} * {16'd0, ob_d_ff[Lat-1]};
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= {16'd0, c_ff[i][Lat]} * 32'(CodeSq);
         dn_ff[i]  <= {16'd0, sx_ff[i]} * {16'd0, ob_d_ff[0]};
      end
   end
   // decode product reaches Lat+1 path early; delay it
   logic [31:0] dd_ff [Lat-1];
   always_ff @(posedge clock) begin
      dd_ff[0] <= dn_ff[0];
      for (int k = 0; k < Lat - 2; k++) dd_ff[k+1] <= dd_ff[k];
   end
   logic [31:0] dd1_ff [Lat-1], dd2_ff [Lat-1];
   always_ff @(posedge clock) begin
      dd1_ff[0] <= dn_ff[1];
      dd2_ff[0] <= dn_ff[2];
      for (int k = 0; k < Lat - 2; k++) begin
         dd1_ff[k+1] <= dd1_ff[k];
         dd2_ff[k+1] <= dd2_ff[k];
      end
   end
   // at index Lat+1 (after num_ff): select operands
   logic [31:0] an [3];
   logic [31:0] ad;
   logic        enc1;
   assign enc1 = (md_ff[Lat+1] == MODE_ENC);
   assign an[0] = enc1 ? num_ff[0] : dd_ff[Lat-2];
   assign an[1] = enc1 ? num_ff[1] : dd1_ff[Lat-2];
   assign an[2] = enc1 ? num_ff[2] : dd2_ff[Lat-2];
   assign ad    = enc1 ? den_ff : 32'(CodeSq);
   logic [7:0] scl_d_ff [Lat];
   always_ff @(posedge clock) begin
      scl_d_ff[0] <= scl_ff;
      for (int k = 0; k < Lat - 1; k++) scl_d_ff[k+1] <= scl_d_ff[k];
   end
   logic [16:0] q [3];
   logic [31:0] an_ff [3];
   logic [31:0] ad_ff;
   always_ff @(posedge clock) begin
      an_ff <= an;
      ad_ff <= ad;
   end
   for (genvar i = 0; i < 3; i++) begin : g_div
      hrspc_div u_div (.clock(clock), .num(an_ff[i]), .den(ad_ff), .quot(q[i]));
   end
   // q valid at index 2*Lat+1 = Tot
   logic [15:0] res [3];
   logic        enc2;
   assign enc2 = (md_ff[Tot] == MODE_ENC);
   always_comb
      for (int i = 0; i < 3; i++) begin
         if (enc2) res[i] = blk_ff[Tot] ? 16'd0 :
                            ((q[i] > 17'd255) ? 16'd255 : {8'd0, q[i][7:0]});
         else      res[i] = q[i][15:0];
      end
   assign strobe        = v_ff[Tot];
   assign rsp_red_out   = res[0];
   assign rsp_green_out = res[1];
   assign rsp_blue_out  = res[2];
   assign rsp_scale_out = enc2 ? (blk_ff[Tot] ? 8'd0 : scl_d_ff[Lat-1]) : sc_ff[Tot];
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the HDR RGB scale pixel codec: directed table, random items, predictor check.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hrspc_pkg::*;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [7:0]  scale;
   } pixel_type;

   typedef struct {
      logic        mode;
      logic [15:0] obrite;
      pixel_type   pix;
      logic        has_exp;
      pixel_type   exp_pix;
   } vec_type;

   logic        clock, reset, start, busy, strobe;
   logic [15:0] req_red_in, req_green_in, req_blue_in;
   logic [7:0]  req_scale_in;
   logic [15:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [7:0]  rsp_scale_out;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   logic        cur_mode;
   logic [15:0] cur_obrite;
   pixel_type   pending_px[$];
   int          errors = 0;
   int          idle_cycles = 0;
   vec_type     dir_tab[$];

   hdr_rgb_scale_pixel_codec u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic pixel_type codec_predict(logic mode, logic [15:0] ob, pixel_type p);
      longint unsigned c[3], v[3], m, s, q, o;
      pixel_type r;
      o = ob;
      v[0] = p.red; v[1] = p.green; v[2] = p.blue;
      s = p.scale;
      r = '0;
      if (mode == MODE_DEC) begin
         for (int i = 0; i < 3; i++) begin
            c[i] = (v[i] > CodeMax) ? CodeMax : v[i];
            v[i] = (s * c[i] * o) / CodeSq;
         end
         r.red = 16'(v[0]); r.green = 16'(v[1]); r.blue = 16'(v[2]); r.scale = 8'(s);
         return r;
      end
      m = 0;
      for (int i = 0; i < 3; i++) begin
         c[i] = (v[i] < o) ? v[i] : o;
         if (c[i] > m) m = c[i];
      end
      if (m == 0) return r;
      s = (m * CodeMax + o - 1) / o;
      if (s > CodeMax) s = CodeMax;
      for (int i = 0; i < 3; i++) begin
         q = (CodeSq * c[i]) / (s * o);
         v[i] = (q > CodeMax) ? CodeMax : q;
      end
      r.red = 16'(v[0]); r.green = 16'(v[1]); r.blue = 16'(v[2]); r.scale = 8'(s);
      return r;
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_MODE) cur_mode = val[0];
      else cur_obrite = val;
   endtask

   task automatic drain;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic set_cfg(logic mode, logic [15:0] ob);
      if (mode != cur_mode || ob != cur_obrite) begin
         start <= 1'b0;
         drain();
         csr_write(CSR_MODE, {15'd0, mode});
         csr_write(CSR_OBRITE, ob);
         csr_we <= 1'b0;
      end
   endtask

   task automatic send_pixel(pixel_type p, bit chk, pixel_type ex);
      pixel_type pr;
      int gap;
      pr = codec_predict(cur_mode, cur_obrite, p);
      if (chk && pr !== ex) begin
         $display("%0t table row disagrees: expected %h got %h", $time, ex, pr);
         errors++;
      end
      start <= 1'b1;
      req_red_in <= p.red;
      req_green_in <= p.green;
      req_blue_in <= p.blue;
      req_scale_in <= p.scale;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_px.push_back(pr);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset) begin
         if (strobe) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_scale_out};
            if (pending_px.size() == 0) begin
               $display("%0t unexpected result %h", $time, got);
               errors++;
            end else begin
               want = pending_px.pop_front();
               if (got.red !== want.red)
                  $display("%0t red exp %h act %h", $time, want.red, got.red);
               if (got.green !== want.green)
                  $display("%0t green exp %h act %h", $time, want.green, got.green);
               if (got.blue !== want.blue)
                  $display("%0t blue exp %h act %h", $time, want.blue, got.blue);
               if (got.scale !== want.scale)
                  $display("%0t scale exp %h act %h", $time, want.scale, got.scale);
               if (got !== want) errors++;
            end
         end
         if (strobe || (start && !busy) || csr_we) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("hdr_rgb_scale_pixel_codec verification failed");
            $finish;
         end
      end
   end

   function automatic vec_type row(logic md, logic [15:0] ob, logic [15:0] r, logic [15:0] g,
                                   logic [15:0] b, logic [7:0] s, bit he, pixel_type ex);
      vec_type v;
      v.mode = md; v.obrite = ob; v.pix = {r, g, b, s}; v.has_exp = he; v.exp_pix = ex;
      return v;
   endfunction

   initial begin
      pixel_type   p;
      logic        md;
      logic [15:0] ob;
      start = 0; reset = 1; csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_red_in = '0; req_green_in = '0; req_blue_in = '0; req_scale_in = '0;
      cur_mode = MODE_ENC; cur_obrite = 16'd4096;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // black, full, clamp, channels, saturation
      dir_tab.push_back(row(MODE_ENC, 4096, 0, 0, 0, 8'hff, 1, '0));
      dir_tab.push_back(row(MODE_ENC, 4096, 4096, 4096, 4096, 0, 1,
                            {16'd255, 16'd255, 16'd255, 8'd255}));
      dir_tab.push_back(row(MODE_ENC, 4096, 16'hffff, 0, 0, 0, 1,
                            {16'd255, 16'd0, 16'd0, 8'd255}));
      dir_tab.push_back(row(MODE_ENC, 4096, 0, 16'hffff, 1, 8'h55, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 4096, 1, 2, 16'h8000, 8'haa, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 4096, 1, 1, 1, 0, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 4096, 4095, 4080, 17, 0, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 16'hffff, 16'hffff, 16'haaaa, 16'h5555, 0, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 16'hffff, 1, 0, 0, 0, 0, '0));
      dir_tab.push_back(row(MODE_ENC, 1, 16'hffff, 0, 1, 0, 1,
                            {16'd255, 16'd0, 16'd255, 8'd255}));
      dir_tab.push_back(row(MODE_ENC, 0, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1, '0));
      dir_tab.push_back(row(MODE_DEC, 0, 255, 255, 255, 255, 1,
                            {16'd0, 16'd0, 16'd0, 8'd255}));
      dir_tab.push_back(row(MODE_DEC, 16'hffff, 255, 255, 255, 255, 1,
                            {16'hffff, 16'hffff, 16'hffff, 8'd255}));
      dir_tab.push_back(row(MODE_DEC, 16'hffff, 16'hffff, 16'h0100, 0, 255, 1,
                            {16'hffff, 16'hffff, 16'h0, 8'd255}));
      dir_tab.push_back(row(MODE_DEC, 16'hffff, 255, 1, 128, 0, 1,
                            {16'd0, 16'd0, 16'd0, 8'd0}));
      dir_tab.push_back(row(MODE_DEC, 4096, 100, 200, 17, 128, 0, '0));
      dir_tab.push_back(row(MODE_DEC, 1, 255, 254, 1, 255, 0, '0));
      dir_tab.push_back(row(MODE_DEC, 4096, 16'haaaa, 16'h5555, 16'h00ff, 8'h55, 0, '0));

      foreach (dir_tab[i]) begin
         set_cfg(dir_tab[i].mode, dir_tab[i].obrite);
         send_pixel(dir_tab[i].pix, dir_tab[i].has_exp, dir_tab[i].exp_pix);
      end
      start <= 1'b0;
      // hold off until the pipe is empty
      do @(posedge clock); while (pending_px.size() != 0);

      for (int n = 0; n < 450; n++) begin
         if (n % 50 == 0) begin
            md = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
               0: ob = 16'hffff;
               1: ob = 16'd1;
               2: ob = 16'd0;
               3: ob = 16'd4096;
               default: ob = 16'($urandom_range(1, 16'hffff));
            endcase
            set_cfg(md, ob);
         end
         p.scale = 8'($urandom);
         if (cur_mode == MODE_DEC && $urandom_range(0, 3) != 0) begin
            p.red = 16'($urandom_range(0, 255));
            p.green = 16'($urandom_range(0, 255));
            p.blue = 16'($urandom_range(0, 255));
         end else if ($urandom_range(0, 2) == 0) begin
            p.red = 16'($urandom); p.green = 16'($urandom); p.blue = 16'($urandom);
         end else begin
            p.red = 16'($urandom_range(0, cur_obrite));
            p.green = 16'($urandom_range(0, cur_obrite));
            p.blue = 16'($urandom_range(0, cur_obrite));
         end
         send_pixel(p, 0, '0);
      end
      start <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      if (errors == 0) begin
         $display("hdr_rgb_scale_pixel_codec verification clean");
      end else begin
         $display("hdr_rgb_scale_pixel_codec verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/hrspc_pkg.sv
hw/rtl/hrspc_div.sv
hw/rtl/hdr_rgb_scale_pixel_codec.sv
tb/sv/tb_top.sv
